// ===== hw/rtl/mshr_pkg.sv =====
// Package: types and constants shared by the miss status table modules.
`timescale 1ns / 1ps
package mshr_pkg;
  localparam int ENTRIES = 8;
  localparam int MAX_SECONDARIES = 4;
  localparam int IDX_W = 3;
  localparam int SEC_W = 2;
  localparam int CNT_W = 3;
  localparam int VCNT_W = 4;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_REL    = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  localparam logic [3:0] ST_MERGED    = 4'd0;
  localparam logic [3:0] ST_ALLOC     = 4'd1;
  localparam logic [3:0] ST_FULL      = 4'd2;
  localparam logic [3:0] ST_MERGEFULL = 4'd3;
  localparam logic [3:0] ST_FOUND     = 4'd4;
  localparam logic [3:0] ST_NOTFOUND  = 4'd5;
  localparam logic [3:0] ST_FREED     = 4'd6;
  localparam logic [3:0] ST_PROMOTED  = 4'd7;
  localparam logic [3:0] ST_SECREM    = 4'd8;
  localparam logic [3:0] ST_UNKNOWN   = 4'd9;
  localparam logic [3:0] ST_TICKED    = 4'd10;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] req_id;
    logic [63:0] line_address;
    logic [1:0]  access_kind;
    logic [63:0] instr_pc;
    logic [63:0] due_time;
    logic [63:0] now_time;
    logic [31:0] result_word;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  slot_index;
    logic [63:0] slot_primary_id;
    logic [63:0] slot_line_address;
    logic [1:0]  slot_access_kind;
    logic [63:0] slot_pc;
    logic [63:0] slot_due_time;
    logic        slot_ready;
    logic [31:0] slot_result;
    logic        table_full;
    logic [3:0]  valid_count;
  } out_item_t;

  // Contents of one entry as seen by the result path.
  typedef struct packed {
    logic        valid;
    logic        done;
    logic [63:0] primary;
    logic [63:0] line;
    logic [1:0]  kind;
    logic [63:0] pc;
    logic [63:0] due;
    logic [31:0] payload;
    logic [CNT_W-1:0] sec_count;
    logic [63:0] sec0;
  } entry_t;

  // Per-cell match flags and the grant coming back from the priority chain.
  typedef struct packed {
    logic line_hit;
    logic prim_hit;
    logic sec_hit;
    logic free;
  } cell_flags_t;

  typedef struct packed {
    logic merge;
    logic fill;
    logic release_id;
  } cell_grant_t;
endpackage

// ===== hw/rtl/mshr_cell.sv =====
// One table entry: its stored fields, its secondary list and its match logic.
`timescale 1ns / 1ps
module mshr_cell import mshr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  in_item_t    item,
  input  cell_grant_t grant,
  output cell_flags_t flags,
  output entry_t      ent
);
  logic        valid_r, done_r;
  logic [63:0] primary_r, line_r, pc_r, due_r;
  logic [1:0]  kind_r;
  logic [31:0] payload_r;
  logic [CNT_W-1:0] cnt_r;
  logic [63:0] sec_r [MAX_SECONDARIES];
  logic [MAX_SECONDARIES-1:0] sec_match;
  logic [SEC_W-1:0] first_pos;

  always_comb begin
    first_pos = '0;
    for (int k = MAX_SECONDARIES - 1; k >= 0; k--) begin
      sec_match[k] = (CNT_W'(k) < cnt_r) && (sec_r[k] == item.req_id);
      if (sec_match[k]) first_pos = SEC_W'(k);
    end
  end

  assign flags.line_hit = valid_r && (line_r == item.line_address);
  assign flags.prim_hit = valid_r && (primary_r == item.req_id);
  assign flags.sec_hit  = valid_r && (|sec_match);
  assign flags.free     = !valid_r;

  assign ent = '{valid: valid_r, done: done_r, primary: primary_r, line: line_r,
                 kind: kind_r, pc: pc_r, due: due_r, payload: payload_r,
                 sec_count: cnt_r, sec0: sec_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (go) begin
      if (item.opcode == OP_TICK) begin
        if (valid_r && (item.now_time >= due_r)) done_r <= 1'b1;
      end
      if (grant.fill) begin
        valid_r   <= 1'b1;
        done_r    <= 1'b0;
        primary_r <= item.req_id;
        line_r    <= item.line_address;
        kind_r    <= item.access_kind;
        pc_r      <= item.instr_pc;
        due_r     <= item.due_time;
        payload_r <= item.result_word;
        cnt_r     <= '0;
      end
      if (grant.merge && (cnt_r < CNT_W'(MAX_SECONDARIES))) begin
        sec_r[cnt_r[SEC_W-1:0]] <= item.req_id;
        cnt_r <= cnt_r + 1'b1;
      end
      if (grant.release_id) begin
        if (flags.prim_hit) begin
          if (cnt_r == '0) begin
            valid_r <= 1'b0;
            done_r  <= 1'b0;
          end else begin
            primary_r <= sec_r[0];
            for (int k = 0; k < MAX_SECONDARIES - 1; k++) sec_r[k] <= sec_r[k+1];
            cnt_r <= cnt_r - 1'b1;
          end
        end else begin
          for (int k = 0; k < MAX_SECONDARIES - 1; k++)
            if (SEC_W'(k) >= first_pos) sec_r[k] <= sec_r[k+1];
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/miss_status_holding_table.sv =====
// Top level: miss status table with a row of entry cells and a registered result.
//
//   channel | direction | payload
//   in_     | input     | in_item_t
//   out_    | output    | out_item_t
//
// For each item, the entry row is read and matched in the cycle after
// acceptance, where the result is formed, and the row is updated at the same edge
// that registers the result. The input stalls from acceptance until that commit,
// and the commit waits while an earlier result beat is still stalled.
// Reset clears all valid flags, ready flags and counts at once.
`timescale 1ns / 1ps
module miss_status_holding_table import mshr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  logic        busy_r;
  in_item_t    item_r;
  logic        out_valid_r;
  out_item_t   out_r;
  cell_flags_t flags [ENTRIES];
  cell_grant_t grant [ENTRIES];
  entry_t      ents  [ENTRIES];
  logic        go;
  logic [IDX_W-1:0] sel;
  logic        any_line, any_free, any_rel, any_look;
  logic [IDX_W-1:0] i_line, i_free, i_rel, i_look;
  logic [VCNT_W-1:0] vcnt_nxt;
  out_item_t   res;
  entry_t      e;

  // Commit when the output register is or becomes empty.
  assign go       = busy_r && (!out_valid_r || !out_stall);
  assign in_stall = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      mshr_cell u_cell (.clk(clk), .rst_n(rst_n), .go(go), .item(item_r),
                        .grant(grant[g]), .flags(flags[g]), .ent(ents[g]));
    end
  endgenerate

  always_comb begin
    any_line = 1'b0; any_free = 1'b0; any_rel = 1'b0; any_look = 1'b0;
    i_line = '0; i_free = '0; i_rel = '0; i_look = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (flags[i].line_hit) begin any_line = 1'b1; i_line = IDX_W'(i); end
      if (flags[i].free) begin any_free = 1'b1; i_free = IDX_W'(i); end
      if (flags[i].prim_hit || flags[i].sec_hit) begin
        any_rel = 1'b1; i_rel = IDX_W'(i);
      end
    end
    any_look = any_rel;
    i_look = i_rel;
    for (int i = 0; i < ENTRIES; i++) begin
      grant[i].merge = (item_r.opcode == OP_ALLOC) && any_line && (i_line == IDX_W'(i));
      grant[i].fill  = (item_r.opcode == OP_ALLOC) && !any_line && any_free
                       && (i_free == IDX_W'(i));
      grant[i].release_id = (item_r.opcode == OP_REL) && any_rel && (i_rel == IDX_W'(i));
    end
  end

  always_comb begin
    vcnt_nxt = '0;
    for (int i = 0; i < ENTRIES; i++)
      vcnt_nxt = vcnt_nxt + VCNT_W'(ents[i].valid);
    res = '0;
    sel = '0;
    e = '0;
    unique case (item_r.opcode)
      OP_ALLOC: begin
        if (any_line) begin
          sel = i_line; e = ents[i_line];
          res.status = (e.sec_count >= CNT_W'(MAX_SECONDARIES)) ? ST_MERGEFULL : ST_MERGED;
        end else if (any_free) begin
          sel = i_free;
          e = '{valid: 1'b1, done: 1'b0, primary: item_r.req_id,
                line: item_r.line_address, kind: item_r.access_kind,
                pc: item_r.instr_pc, due: item_r.due_time,
                payload: item_r.result_word, sec_count: '0, sec0: '0};
          res.status = ST_ALLOC;
          vcnt_nxt = vcnt_nxt + 1'b1;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_REL: begin
        if (any_rel) begin
          sel = i_rel; e = ents[i_rel];
          if (flags[i_rel].prim_hit) begin
            if (e.sec_count == '0) begin
              res.status = ST_FREED; e.done = 1'b0; vcnt_nxt = vcnt_nxt - 1'b1;
            end else begin
              // The oldest secondary becomes the primary at this edge.
              res.status = ST_PROMOTED; e.primary = e.sec0;
            end
          end else begin
            res.status = ST_SECREM;
          end
        end else begin
          res.status = ST_UNKNOWN;
        end
      end
      OP_TICK: res.status = ST_TICKED;
      OP_LOOKUP: begin
        if (any_look) begin
          sel = i_look; e = ents[i_look]; res.status = ST_FOUND;
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      default: res.status = ST_TICKED;
    endcase
    if (res.status != ST_FULL && res.status != ST_UNKNOWN && res.status != ST_TICKED
        && res.status != ST_NOTFOUND) begin
      res.slot_index = sel;
      res.slot_primary_id = e.primary;
      res.slot_line_address = e.line;
      res.slot_access_kind = e.kind;
      res.slot_pc = e.pc;
      res.slot_due_time = e.due;
      res.slot_ready = e.done;
      res.slot_result = e.payload;
    end
    res.table_full = (vcnt_nxt == VCNT_W'(ENTRIES));
    res.valid_count = vcnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
        if (in_valid && !in_stall) busy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item_r <= in_data;
    if (go) out_r <= res;
  end

  assert property (@(posedge clk) disable iff (!rst_n) go |=> out_valid)
    else $error("result not registered after commit");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.valid_count <= VCNT_W'(ENTRIES))
    else $error("occupancy beyond table size");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.table_full == (out_data.valid_count == VCNT_W'(ENTRIES))))
    else $error("full flag disagrees with count");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");
endmodule
